// ===== design/ffha_pkg.sv =====
// shared constants and types for the first-fit heap allocator
package ffha_pkg;

  localparam int HEAP_BYTES_DEF   = 1024;
  localparam int HEADER_BYTES_DEF = 16;
  localparam int MAX_BLOCKS_DEF   = 64;

  localparam int ADDR_W   = 10;
  localparam int STATUS_W = 2;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOFIT   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BADFREE = 2'd2;

  typedef struct packed {
    logic                valid;
    logic [ADDR_W-1:0]   addr;
    logic [STATUS_W-1:0] status;
  } result_t;

endpackage

// ===== design/ffha_ram.sv =====
// generic single-write, single-read ram with registered read data
module ffha_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/ffha_seq.sv =====
// request sequencer: scans the block table, splits, merges and shifts entries
module ffha_seq #(
  parameter int HEAP_BYTES   = ffha_pkg::HEAP_BYTES_DEF,
  parameter int HEADER_BYTES = ffha_pkg::HEADER_BYTES_DEF,
  parameter int MAX_BLOCKS   = ffha_pkg::MAX_BLOCKS_DEF,
  localparam int AW = $clog2(HEAP_BYTES),
  localparam int IW = $clog2(MAX_BLOCKS),
  localparam int EW = 2 * AW + 1
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        cmd,
  input  logic [ffha_pkg::ADDR_W-1:0] req_size,
  input  logic [ffha_pkg::ADDR_W-1:0] payload_addr,
  output ffha_pkg::result_t           res,
  input  logic                        res_ready,
  output logic                        ram_we,
  output logic [IW-1:0]               ram_waddr,
  output logic [EW-1:0]               ram_wdata,
  output logic [IW-1:0]               ram_raddr,
  input  logic [EW-1:0]               ram_rdata
);

  localparam int CW = $clog2(MAX_BLOCKS + 1);
  localparam int XW = ((AW > ffha_pkg::ADDR_W) ? AW : ffha_pkg::ADDR_W) + 2;
  localparam logic [XW-1:0] HDR_X = XW'(HEADER_BYTES);
  localparam logic [AW-1:0] INIT_SIZE = AW'(HEAP_BYTES - HEADER_BYTES);

  localparam logic [3:0] S_INIT = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_SCAN = 4'd2;
  localparam logic [3:0] S_SHUP = 4'd3;
  localparam logic [3:0] S_WNEW = 4'd4;
  localparam logic [3:0] S_WHIT = 4'd5;
  localparam logic [3:0] S_FRN  = 4'd6;
  localparam logic [3:0] S_FRP  = 4'd7;
  localparam logic [3:0] S_SHDN = 4'd8;
  localparam logic [3:0] S_RESP = 4'd9;

  typedef struct packed {
    logic          used;
    logic [AW-1:0] size;
    logic [AW-1:0] start;
  } entry_t;

  logic [3:0]                    state;
  logic [CW-1:0]                 cnt;
  logic [IW-1:0]                 dptr;
  logic [IW-1:0]                 hit;
  logic [IW-1:0]                 sj;
  entry_t                        ent;
  logic                          op_cmd;
  logic [ffha_pkg::ADDR_W-1:0]   req_r;
  logic [ffha_pkg::ADDR_W-1:0]   pa_r;
  logic                          split_r;
  logic                          nfree;
  logic [AW-1:0]                 nsize;
  logic [1:0]                    shift_dist;
  logic [ffha_pkg::ADDR_W-1:0]   res_addr;
  logic [ffha_pkg::STATUS_W-1:0] res_status;

  entry_t        e;
  logic          alloc_hit;
  logic          free_hit;
  logic          hit_now;
  logic          last;
  logic [XW-1:0] left;
  logic          split;
  logic          shift_up;
  logic          pfree;
  logic [XW-1:0] mid;
  logic [XW-1:0] msize;
  logic [AW-1:0] mstart;
  logic [IW-1:0] lo;
  logic [IW-1:0] hi;
  logic [1:0]    d;
  logic          tail;
  logic [XW-1:0] paddr_x;

  always_comb begin
    e         = entry_t'(ram_rdata);
    alloc_hit = !e.used && (XW'(e.size) >= XW'(req_r));
    free_hit  = (XW'(e.start) + HDR_X) == XW'(pa_r);
    hit_now   = (op_cmd == ffha_pkg::CMD_ALLOC) ? alloc_hit : free_hit;
    last      = CW'(dptr) == (cnt - 1'b1);
    left      = XW'(e.size) - XW'(req_r);
    split     = (left > HDR_X) && (cnt < CW'(MAX_BLOCKS));
    shift_up  = (CW'(dptr) + 1'b1) < cnt;
    // merge of a free neighbor on either side
    pfree     = (hit != '0) && !e.used;
    mid       = XW'(ent.size) + (nfree ? (HDR_X + XW'(nsize)) : '0);
    msize     = pfree ? (XW'(e.size) + HDR_X + mid) : mid;
    mstart    = pfree ? e.start : ent.start;
    lo        = pfree ? (hit - 1'b1) : hit;
    hi        = hit + IW'(nfree);
    d         = 2'(pfree) + 2'(nfree);
    tail      = (CW'(hi) + 1'b1) < cnt;
    paddr_x   = XW'(ent.start) + HDR_X;
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_raddr = '0;
    case (state)
      S_INIT: begin
        ram_we    = 1'b1;
        ram_wdata = {1'b0, INIT_SIZE, AW'(0)};
      end
      S_SCAN: begin
        ram_raddr = dptr + 1'b1;
        if (hit_now && op_cmd == ffha_pkg::CMD_ALLOC && split && shift_up) begin
          ram_raddr = IW'(cnt - 1'b1);
        end
      end
      S_SHUP: begin
        ram_we    = 1'b1;
        ram_waddr = sj + 1'b1;
        ram_wdata = ram_rdata;
        ram_raddr = sj - 1'b1;
      end
      S_WNEW: begin
        ram_we    = 1'b1;
        ram_waddr = hit + 1'b1;
        ram_wdata = {1'b0, AW'(XW'(ent.size) - XW'(req_r) - HDR_X),
                     AW'(paddr_x + XW'(req_r))};
      end
      S_WHIT: begin
        ram_we    = 1'b1;
        ram_waddr = hit;
        ram_wdata = {1'b1, split_r ? AW'(req_r) : ent.size, ent.start};
      end
      S_FRN: begin
        ram_raddr = hit - 1'b1;
      end
      S_FRP: begin
        ram_we    = 1'b1;
        ram_waddr = lo;
        ram_wdata = {1'b0, AW'(msize), mstart};
        ram_raddr = hi + 1'b1;
      end
      S_SHDN: begin
        ram_we    = 1'b1;
        ram_waddr = sj - IW'(shift_dist);
        ram_wdata = ram_rdata;
        ram_raddr = sj + 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      cnt   <= CW'(1);
    end else begin
      case (state)
        S_INIT: begin
          state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid) begin
            op_cmd <= cmd;
            req_r  <= req_size;
            pa_r   <= payload_addr;
            dptr   <= '0;
            state  <= S_SCAN;
          end
        end
        S_SCAN: begin
          res_addr <= '0;
          if (hit_now) begin
            hit <= dptr;
            ent <= e;
            if (op_cmd == ffha_pkg::CMD_ALLOC) begin
              split_r <= split;
              if (split && shift_up) begin
                sj    <= IW'(cnt - 1'b1);
                state <= S_SHUP;
              end else if (split) begin
                state <= S_WNEW;
              end else begin
                state <= S_WHIT;
              end
            end else if (!e.used) begin
              // double free
              res_status <= ffha_pkg::ST_BADFREE;
              state      <= S_RESP;
            end else begin
              state <= S_FRN;
            end
          end else if (last) begin
            res_status <= (op_cmd == ffha_pkg::CMD_ALLOC) ? ffha_pkg::ST_NOFIT
                                                           : ffha_pkg::ST_BADFREE;
            state      <= S_RESP;
          end else begin
            dptr <= dptr + 1'b1;
          end
        end
        S_SHUP: begin
          if (sj == hit + 1'b1) begin
            state <= S_WNEW;
          end else begin
            sj <= sj - 1'b1;
          end
        end
        S_WNEW: begin
          state <= S_WHIT;
        end
        S_WHIT: begin
          if (split_r) begin
            cnt <= cnt + 1'b1;
          end
          res_addr   <= paddr_x[ffha_pkg::ADDR_W-1:0];
          res_status <= ffha_pkg::ST_OK;
          state      <= S_RESP;
        end
        S_FRN: begin
          nfree <= ((CW'(hit) + 1'b1) < cnt) && !e.used;
          nsize <= e.size;
          state <= S_FRP;
        end
        S_FRP: begin
          shift_dist <= d;
          res_status <= ffha_pkg::ST_OK;
          if (tail && d != 2'd0) begin
            sj    <= hi + 1'b1;
            state <= S_SHDN;
          end else begin
            cnt   <= cnt - CW'(d);
            state <= S_RESP;
          end
        end
        S_SHDN: begin
          if (CW'(sj) == cnt - 1'b1) begin
            cnt   <= cnt - CW'(shift_dist);
            state <= S_RESP;
          end else begin
            sj <= sj + 1'b1;
          end
        end
        S_RESP: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign in_stall   = state != S_IDLE;
  assign res.valid  = state == S_RESP;
  assign res.addr   = res_addr;
  assign res.status = res_status;

endmodule

// ===== design/first_fit_heap_allocator.sv =====
// First-fit heap allocator with coalescing. Blocks are kept in address order in one
// MAX_BLOCKS-entry table ram (start, payload size, used bit) and every request walks
// that table one entry per cycle through the ram's single read port. A split shifts the
// entries above the found entry up and a merge shifts them down, one entry per cycle.
// Items are taken one at a time; the result sits in an output register, so the next
// item is accepted while it waits. After reset the initial free block is written
// before the first item is taken.
module first_fit_heap_allocator #(
  parameter int HEAP_BYTES   = ffha_pkg::HEAP_BYTES_DEF,
  parameter int HEADER_BYTES = ffha_pkg::HEADER_BYTES_DEF,
  parameter int MAX_BLOCKS   = ffha_pkg::MAX_BLOCKS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          cmd,
  input  logic [ffha_pkg::ADDR_W-1:0]   req_size,
  input  logic [ffha_pkg::ADDR_W-1:0]   payload_addr,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [ffha_pkg::ADDR_W-1:0]   addr,
  output logic [ffha_pkg::STATUS_W-1:0] status
);

  localparam int AW = $clog2(HEAP_BYTES);
  localparam int IW = $clog2(MAX_BLOCKS);
  localparam int EW = 2 * AW + 1;

  ffha_pkg::result_t res;
  logic              res_ready;
  logic              ram_we;
  logic [IW-1:0]     ram_waddr;
  logic [EW-1:0]     ram_wdata;
  logic [IW-1:0]     ram_raddr;
  logic [EW-1:0]     ram_rdata;

  ffha_seq #(
    .HEAP_BYTES   (HEAP_BYTES),
    .HEADER_BYTES (HEADER_BYTES),
    .MAX_BLOCKS   (MAX_BLOCKS)
  ) u_seq (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .cmd          (cmd),
    .req_size     (req_size),
    .payload_addr (payload_addr),
    .res          (res),
    .res_ready    (res_ready),
    .ram_we       (ram_we),
    .ram_waddr    (ram_waddr),
    .ram_wdata    (ram_wdata),
    .ram_raddr    (ram_raddr),
    .ram_rdata    (ram_rdata)
  );

  ffha_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_BLOCKS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign res_ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res.valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid && res_ready) begin
      addr   <= res.addr;
      status <= res.status;
    end
  end

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("item accepted while another is in work");

  a_fail_zero_addr: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ffha_pkg::ST_OK) |-> addr == '0)
    else $error("failed request carries an address");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == ffha_pkg::ST_OK || status == ffha_pkg::ST_NOFIT ||
                   status == ffha_pkg::ST_BADFREE))
    else $error("undefined status code");

  a_load_free_slot: assert property (@(posedge clk) disable iff (rst)
    (res.valid && !res_ready) |=> res.valid)
    else $error("result dropped while output register full");

endmodule

// ===== tb/first_fit_heap_allocator_checker.sv =====
// checker that predicts and compares allocator results
`timescale 1ns / 1ps
module first_fit_heap_allocator_checker #(
  parameter int HEAP_BYTES   = ffha_pkg::HEAP_BYTES_DEF,
  parameter int HEADER_BYTES = ffha_pkg::HEADER_BYTES_DEF,
  parameter int MAX_BLOCKS   = ffha_pkg::MAX_BLOCKS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic                          cmd,
  input  logic [ffha_pkg::ADDR_W-1:0]   req_size,
  input  logic [ffha_pkg::ADDR_W-1:0]   payload_addr,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [ffha_pkg::ADDR_W-1:0]   addr,
  input  logic [ffha_pkg::STATUS_W-1:0] status,
  output int                            errors,
  output int                            pending
);

  typedef struct {
    int unsigned start;
    int unsigned size;
    bit          used;
  } heap_block_t;

  typedef struct {
    logic [ffha_pkg::ADDR_W-1:0]   addr;
    logic [ffha_pkg::STATUS_W-1:0] status;
  } grant_t;

  heap_block_t blocks[MAX_BLOCKS];
  int unsigned nblocks;
  grant_t      grants_q[$];

  function automatic void heap_reset();
    foreach (blocks[k]) blocks[k] = '{0, 0, 0};
    blocks[0] = '{0, HEAP_BYTES - HEADER_BYTES, 0};
    nblocks = 1;
  endfunction

  function automatic void remove_block(int unsigned idx);
    for (int unsigned k = idx; k + 1 < nblocks; k++) blocks[k] = blocks[k + 1];
    nblocks--;
    blocks[nblocks] = '{0, 0, 0};
  endfunction

  function automatic grant_t heap_step(logic op, int unsigned req, int unsigned pa);
    grant_t g;
    int unsigned i;
    int unsigned left;
    g = '{'0, ffha_pkg::ST_OK};
    if (op == ffha_pkg::CMD_ALLOC) begin
      for (i = 0; i < nblocks; i++)
        if (!blocks[i].used && blocks[i].size >= req) break;
      if (i >= nblocks) begin
        g.status = ffha_pkg::ST_NOFIT;
        return g;
      end
      left = blocks[i].size - req;
      if (left > HEADER_BYTES && nblocks < MAX_BLOCKS) begin
        for (int unsigned k = nblocks; k > i + 1; k--) blocks[k] = blocks[k - 1];
        blocks[i + 1] = '{blocks[i].start + HEADER_BYTES + req, left - HEADER_BYTES, 0};
        blocks[i].size = req;
        nblocks++;
      end
      blocks[i].used = 1;
      g.addr = ffha_pkg::ADDR_W'(blocks[i].start + HEADER_BYTES);
    end else begin
      for (i = 0; i < nblocks; i++)
        if (blocks[i].start + HEADER_BYTES == pa) break;
      if (i >= nblocks || !blocks[i].used) begin
        g.status = ffha_pkg::ST_BADFREE;
        return g;
      end
      blocks[i].used = 0;
      if (i + 1 < nblocks && !blocks[i + 1].used) begin
        blocks[i].size += HEADER_BYTES + blocks[i + 1].size;
        remove_block(i + 1);
      end
      if (i > 0 && !blocks[i - 1].used) begin
        blocks[i - 1].size += HEADER_BYTES + blocks[i].size;
        remove_block(i);
      end
    end
    return g;
  endfunction

  initial begin
    errors = 0;
    pending = 0;
    heap_reset();
  end

  always @(posedge clk) begin
    grant_t exp_g;
    if (rst) begin
      heap_reset();
      grants_q.delete();
    end else begin
      if (in_valid && !in_stall) grants_q.push_back(heap_step(cmd, req_size, payload_addr));
      if (out_valid && !out_stall) begin
        if (grants_q.size() == 0) begin
          $display("%0t: unexpected item addr=%0d status=%0d", $time, addr, status);
          errors++;
        end else begin
          exp_g = grants_q.pop_front();
          if (addr !== exp_g.addr) begin
            $display("%0t: addr expected %0d actual %0d", $time, exp_g.addr, addr);
            errors++;
          end
          if (status !== exp_g.status) begin
            $display("%0t: status expected %0d actual %0d", $time, exp_g.status, status);
            errors++;
          end
        end
      end
    end
    pending = grants_q.size();
  end

endmodule

// ===== tb/first_fit_heap_allocator_tb.sv =====
// stimulus and verdict for the first-fit heap allocator
`timescale 1ns / 1ps
module first_fit_heap_allocator_tb;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0, cmd = 0, out_stall = 0;
  logic [ffha_pkg::ADDR_W-1:0] req_size = '0, payload_addr = '0;
  logic in_stall, out_valid;
  logic [ffha_pkg::ADDR_W-1:0] addr;
  logic [ffha_pkg::STATUS_W-1:0] status;
  int errors, pending;
  int send_idle = 0, recv_idle = 0;
  bit long_hold = 0;
  int quiet = 0;
  // payload addresses handed out so far, for realistic frees
  logic [ffha_pkg::ADDR_W-1:0] live_q[$];

  first_fit_heap_allocator dut (.*);
  first_fit_heap_allocator_checker chk (.*);

  initial forever #1 clk = ~clk;

  // track granted addresses to build plausible frees
  always @(posedge clk)
    if (!rst && out_valid && !out_stall && status == ffha_pkg::ST_OK && addr != 0)
      live_q.push_back(addr);

  // receiver side stalls
  initial begin
    forever begin
      @(negedge clk);
      if (long_hold) out_stall <= 1;
      else out_stall <= ($urandom_range(99) < recv_idle);
    end
  end

  // watchdog on cycles with nothing accepted
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet <= 0;
    else if (!long_hold) quiet <= quiet + 1;
    if (quiet > 20000) begin
      $display("first_fit_heap_allocator_tb failed");
      $finish;
    end
  end

  task automatic send_item(logic op, logic [ffha_pkg::ADDR_W-1:0] sz,
                           logic [ffha_pkg::ADDR_W-1:0] pa);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1;
    cmd <= op;
    req_size <= sz;
    payload_addr <= pa;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic random_item();
    int r, k;
    r = $urandom_range(99);
    if (r < 45) send_item(ffha_pkg::CMD_ALLOC, 0, ffha_pkg::ADDR_W'($urandom));
    else if (r < 85 && live_q.size() > 0) begin
      k = $urandom_range(live_q.size() - 1);
      send_item(ffha_pkg::CMD_FREE, ffha_pkg::ADDR_W'($urandom), live_q[k]);
      live_q.delete(k);
    end else send_item(ffha_pkg::CMD_FREE, ffha_pkg::ADDR_W'($urandom),
                       ffha_pkg::ADDR_W'($urandom));
  endtask

  task automatic alloc_small();
    logic [ffha_pkg::ADDR_W-1:0] sz;
    sz = ($urandom_range(9) == 0) ? ffha_pkg::ADDR_W'($urandom)
                                  : ffha_pkg::ADDR_W'($urandom_range(48));
    send_item(ffha_pkg::CMD_ALLOC, sz, ffha_pkg::ADDR_W'($urandom));
  endtask

  task automatic drain();
    in_valid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (200) @(negedge clk);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    // directed: extremes, split, no split, zero size, bad and double free, merges
    send_item(ffha_pkg::CMD_ALLOC, 1023, 0);
    send_item(ffha_pkg::CMD_ALLOC, 1008, 0);
    send_item(ffha_pkg::CMD_FREE, 0, 16);
    send_item(ffha_pkg::CMD_FREE, 0, 16);
    send_item(ffha_pkg::CMD_FREE, 0, 1023);
    send_item(ffha_pkg::CMD_ALLOC, 0, 0);
    send_item(ffha_pkg::CMD_ALLOC, 100, 0);
    send_item(ffha_pkg::CMD_ALLOC, 200, 0);
    send_item(ffha_pkg::CMD_ALLOC, 690, 0);
    send_item(ffha_pkg::CMD_FREE, 0, 148);
    send_item(ffha_pkg::CMD_FREE, 0, 16);
    send_item(ffha_pkg::CMD_FREE, 0, 32);
    send_item(ffha_pkg::CMD_FREE, 0, 364);
    send_item(ffha_pkg::CMD_ALLOC, 1000, 0);
    send_item(ffha_pkg::CMD_FREE, 0, 16);
    drain();
    live_q.delete();
    // fill the table with tiny blocks
    for (int i = 0; i < 70; i++) send_item(ffha_pkg::CMD_ALLOC, 0, 0);
    drain();
    for (int p = 0; p < 4; p++) begin
      send_idle = (p == 1 || p == 3) ? 67 : 0;
      recv_idle = (p == 2) ? 67 : (p == 3 ? 38 : 0);
      if (p == 3) send_idle = 38;
      for (int i = 0; i < 340; i++) begin
        if ($urandom_range(1)) alloc_small(); else random_item();
      end
      if (p == 0) begin
        // long receiver hold while items keep coming
        fork
          begin
            long_hold = 1;
            repeat (3000) @(negedge clk);
            long_hold = 0;
          end
          begin
            for (int i = 0; i < 6; i++) alloc_small();
            in_valid <= 0;
          end
        join
      end
      drain();
    end
    if (errors == 0) $display("first_fit_heap_allocator_tb passed");
    else $display("first_fit_heap_allocator_tb failed");
    $finish;
  end

endmodule
